// ----- design/annexb_nal_unit_splitter_macros.svh -----
// Assertion helpers used by the splitter's queue module.
`ifndef ANNEXB_NAL_UNIT_SPLITTER_MACROS_SVH
`define ANNEXB_NAL_UNIT_SPLITTER_MACROS_SVH

`ifndef SYNTHESIS
`define ANBS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ANBS_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ANBS_ASSERT(lbl, clk, rst_n, prop, msg)
`define ANBS_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

// ----- design/anbs_pkg.sv -----
package anbs_pkg;

  localparam int PositionBitsDef = 32;

  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [5:0] TypeMask = 6'h3F;
  localparam logic [2:0] TidMask  = 3'h7;

  localparam int OutDataW = 80;

  // One closed unit, as handed from the scanner to the output side.
  typedef struct packed {
    logic [7:0]  hdr_second;
    logic [7:0]  hdr_first;
    logic [31:0] size;
    logic [31:0] offset;
  } unit_rec_t;

endpackage

// ----- design/anbs_front.sv -----
module anbs_front #(
  parameter int POSITION_BITS = anbs_pkg::PositionBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                byte_valid_i,
  input  logic                byte_ready_i,
  input  logic [7:0]          stream_byte_i,
  input  logic                final_byte_i,
  output logic                push_o,
  output anbs_pkg::unit_rec_t rec_o
);

  localparam int PosW  = POSITION_BITS;
  localparam int SizeW = POSITION_BITS + 1;
  localparam int WideW = (SizeW > 32) ? SizeW : 32;
  localparam logic [PosW-1:0] PosMax = {PosW{1'b1}};

  logic [PosW-1:0] pos_q, pos_d;
  logic [1:0]      zero_run_q, zero_run_d;
  logic            inside_q, inside_d;
  logic [PosW-1:0] unit_start_q, unit_start_d;
  logic            lnz_seen_q, lnz_seen_d;
  logic [PosW-1:0] lnz_pos_q, lnz_pos_d;
  logic [7:0]      hdr_first_q, hdr_first_d;
  logic [7:0]      hdr_second_q, hdr_second_d;
  logic [1:0]      hdr_count_q, hdr_count_d;

  logic             accept;
  logic             start_code;
  logic [PosW-1:0]  pos_next;
  logic [SizeW-1:0] size_sc, size_fin, size_sel;
  logic             rep_sc, rep_fin;
  logic [WideW-1:0] size_wide, off_wide;

  assign accept     = byte_valid_i && byte_ready_i;
  assign start_code = (stream_byte_i == 8'd1) && zero_run_q[1];
  assign pos_next   = (pos_q == PosMax) ? pos_q : pos_q + 1'b1;

  assign size_sc  = {1'b0, lnz_pos_q} + 1'b1 - {1'b0, unit_start_q};
  assign size_fin = {1'b0, pos_q} + 1'b1 - {1'b0, unit_start_q};

  assign rep_sc  = start_code && inside_q && lnz_seen_q && (lnz_pos_q >= unit_start_q)
                   && (size_sc >= SizeW'(2));
  assign rep_fin = final_byte_i && !start_code && inside_q && (pos_q >= unit_start_q)
                   && (size_fin >= SizeW'(2));

  assign size_sel  = rep_sc ? size_sc : size_fin;
  assign size_wide = WideW'(size_sel);
  assign off_wide  = WideW'(unit_start_q);

  always_comb begin
    pos_d        = pos_q;
    zero_run_d   = zero_run_q;
    inside_d     = inside_q;
    unit_start_d = unit_start_q;
    lnz_seen_d   = lnz_seen_q;
    lnz_pos_d    = lnz_pos_q;
    hdr_first_d  = hdr_first_q;
    hdr_second_d = hdr_second_q;
    hdr_count_d  = hdr_count_q;
    if (accept) begin
      if (start_code) begin
        inside_d     = 1'b1;
        unit_start_d = pos_next;
        lnz_seen_d   = 1'b0;
        lnz_pos_d    = '0;
        hdr_count_d  = 2'd0;
        zero_run_d   = 2'd0;
      end else begin
        if (inside_q) begin
          if (hdr_count_q == 2'd0) begin
            hdr_first_d = stream_byte_i;
            hdr_count_d = 2'd1;
          end else if (hdr_count_q == 2'd1) begin
            hdr_second_d = stream_byte_i;
            hdr_count_d  = 2'd2;
          end
          if (stream_byte_i != 8'd0) begin
            lnz_pos_d  = pos_q;
            lnz_seen_d = 1'b1;
          end
        end
        if (stream_byte_i == 8'd0) begin
          zero_run_d = zero_run_q[1] ? 2'd2 : zero_run_q + 2'd1;
        end else begin
          zero_run_d = 2'd0;
        end
      end
      // last byte of the buffer: clear position and scan state for the next one
      if (final_byte_i) begin
        pos_d        = '0;
        zero_run_d   = 2'd0;
        inside_d     = 1'b0;
        unit_start_d = '0;
        lnz_seen_d   = 1'b0;
        lnz_pos_d    = '0;
        hdr_count_d  = 2'd0;
      end else begin
        pos_d = pos_next;
      end
    end
  end

  assign push_o           = accept && (rep_sc || rep_fin);
  assign rec_o.offset     = off_wide[31:0];
  assign rec_o.size       = size_wide[31:0];
  assign rec_o.hdr_first  = hdr_first_d;
  assign rec_o.hdr_second = hdr_second_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      zero_run_q   <= 2'd0;
      inside_q     <= 1'b0;
      unit_start_q <= '0;
      lnz_seen_q   <= 1'b0;
      lnz_pos_q    <= '0;
      hdr_count_q  <= 2'd0;
    end else begin
      pos_q        <= pos_d;
      zero_run_q   <= zero_run_d;
      inside_q     <= inside_d;
      unit_start_q <= unit_start_d;
      lnz_seen_q   <= lnz_seen_d;
      lnz_pos_q    <= lnz_pos_d;
      hdr_count_q  <= hdr_count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hdr_first_q  <= hdr_first_d;
    hdr_second_q <= hdr_second_d;
  end

endmodule

// ----- design/anbs_queue.sv -----
`include "annexb_nal_unit_splitter_macros.svh"

module anbs_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  anbs_pkg::unit_rec_t push_rec_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                empty_o,
  output anbs_pkg::unit_rec_t pop_rec_o
);

  localparam int PtrW = anbs_pkg::QueuePtrW;
  localparam int CntW = anbs_pkg::QueueCntW;
  localparam int Depth = anbs_pkg::QueueDepth;
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  anbs_pkg::unit_rec_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o    = (count_q == CntW'(Depth));
  assign empty_o   = (count_q == '0);
  assign pop_rec_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_rec_i;
    end
  end

  `ANBS_NEVER(a_no_push_full, clk_i, rst_ni, push_i && full_o, "push into full queue")
  `ANBS_NEVER(a_no_pop_empty, clk_i, rst_ni, pop_i && empty_o, "pop from empty queue")
  `ANBS_ASSERT(a_count_track, clk_i, rst_ni, (push_i && !pop_i) |=> (count_q == $past(count_q) + 1'b1), "count lost a push")
  `ANBS_NEVER(a_count_range, clk_i, rst_ni, count_q > CntW'(Depth), "count beyond depth")

endmodule

// ----- design/anbs_back.sv -----
module anbs_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           q_empty_i,
  input  anbs_pkg::unit_rec_t            q_rec_i,
  output logic                           q_pop_o,
  output logic                           m_valid_o,
  input  logic                           m_ready_i,
  output logic [anbs_pkg::OutDataW-1:0]  m_data_o
);

  logic                              valid_q, valid_d;
  logic [anbs_pkg::OutDataW-1:0]     data_q, data_d;
  logic                              load;
  logic [5:0]                        unit_type;
  logic [5:0]                        layer_id;
  logic [3:0]                        temporal_id;

  // take a new word when the output register is empty or being drained
  assign load    = !q_empty_i && (!valid_q || m_ready_i);
  assign q_pop_o = load;

  assign unit_type   = q_rec_i.hdr_first[6:1] & anbs_pkg::TypeMask;
  assign layer_id    = {q_rec_i.hdr_first[0], q_rec_i.hdr_second[7:3]};
  assign temporal_id = {1'b0, q_rec_i.hdr_second[2:0] & anbs_pkg::TidMask} - 4'd1;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (load) begin
      valid_d = 1'b1;
      data_d  = {temporal_id, layer_id, unit_type, q_rec_i.size, q_rec_i.offset};
    end else if (m_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign m_valid_o = valid_q;
  assign m_data_o  = data_q;

endmodule

// ----- design/annexb_nal_unit_splitter.sv -----
// Takes one byte word per clock with no gaps while the result queue has room.
// A unit closed by a byte is queued when that byte is accepted, then sent on m_axis.
// The scanner takes each accepted byte as it comes; a two-entry queue plus the output
// register absorb output stalls before s_axis_tready drops.
// rst_ni (asynchronous, active low) clears position, scan state, queue and output valid.
module annexb_nal_unit_splitter #(
  parameter int POSITION_BITS = anbs_pkg::PositionBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] stream_byte
  input  logic        s_axis_tlast,  // final_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [31:0] unit_offset, [63:32] unit_size, [69:64] unit_type,
  // [75:70] layer_id, [79:76] temporal_id
  output logic [anbs_pkg::OutDataW-1:0] m_axis_tdata
);

  logic                push;
  anbs_pkg::unit_rec_t push_rec;
  logic                q_full;
  logic                q_empty;
  logic                q_pop;
  anbs_pkg::unit_rec_t pop_rec;

  assign s_axis_tready = !q_full;

  anbs_front #(
    .POSITION_BITS(POSITION_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (s_axis_tvalid),
    .byte_ready_i (s_axis_tready),
    .stream_byte_i(s_axis_tdata),
    .final_byte_i (s_axis_tlast),
    .push_o       (push),
    .rec_o        (push_rec)
  );

  anbs_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_rec_i(push_rec),
    .full_o    (q_full),
    .pop_i     (q_pop),
    .empty_o   (q_empty),
    .pop_rec_o (pop_rec)
  );

  anbs_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_empty_i(q_empty),
    .q_rec_i  (pop_rec),
    .q_pop_o  (q_pop),
    .m_valid_o(m_axis_tvalid),
    .m_ready_i(m_axis_tready),
    .m_data_o (m_axis_tdata)
  );

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

  // Position width the block is built with here.
  localparam int          PosBits        = 16;
  localparam logic [63:0] PosMax         = (64'd1 << PosBits) - 64'd1;
  localparam int          RandItems      = 826;
  localparam int          PressureAt     = 30;
  localparam int          PressureCycles = 1000;
  // Covers the input gaps per byte, the output stalls per unit and the hold-off.
  localparam int          CycleLimit     = 300_000;
  localparam int          DirRows        = 24;

  // Fields of one reported unit, laid out as on m_axis_tdata.
  typedef struct packed {
    logic [3:0]  tid;
    logic [5:0]  layer;
    logic [5:0]  ntype;
    logic [31:0] size;
    logic [31:0] offset;
  } nal_info_t;

  typedef struct packed {
    logic [7:0] b;
    logic       fin;
    logic       typed;
    nal_info_t  unit;
  } stim_row_t;

  localparam nal_info_t NoUnit = '0;

  // Start code, zero-trimmed unit, all-zero unit, start code on the last byte, then a
  // second buffer closed with an untrimmed trailing zero.
  localparam stim_row_t DirTable [DirRows] = '{
    '{8'h00, 1'b0, 1'b0, NoUnit},
    '{8'h00, 1'b0, 1'b0, NoUnit},
    '{8'h01, 1'b0, 1'b0, NoUnit},
    '{8'h7F, 1'b0, 1'b0, NoUnit},
    '{8'hFF, 1'b0, 1'b0, NoUnit},
    '{8'hAB, 1'b0, 1'b0, NoUnit},
    '{8'h00, 1'b0, 1'b0, NoUnit},
    '{8'h00, 1'b0, 1'b0, NoUnit},
    '{8'h00, 1'b0, 1'b0, NoUnit},
    '{8'h01, 1'b0, 1'b1, '{4'd6, 6'd63, 6'd63, 32'd3, 32'd3}},
    '{8'h00, 1'b0, 1'b0, NoUnit},
    '{8'h00, 1'b0, 1'b0, NoUnit},
    '{8'h01, 1'b0, 1'b0, NoUnit},
    '{8'h80, 1'b0, 1'b0, NoUnit},
    '{8'h08, 1'b0, 1'b0, NoUnit},
    '{8'h00, 1'b0, 1'b0, NoUnit},
    '{8'h00, 1'b0, 1'b0, NoUnit},
    '{8'h01, 1'b1, 1'b1, '{4'hF, 6'd1, 6'd0, 32'd2, 32'd13}},
    '{8'h00, 1'b0, 1'b0, NoUnit},
    '{8'h00, 1'b0, 1'b0, NoUnit},
    '{8'h01, 1'b0, 1'b0, NoUnit},
    '{8'h41, 1'b0, 1'b0, NoUnit},
    '{8'h01, 1'b0, 1'b0, NoUnit},
    '{8'h00, 1'b1, 1'b1, '{4'd0, 6'd32, 6'd32, 32'd3, 32'd3}}
  };

  logic                          clk_i;
  logic                          rst_ni        = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [7:0]                    s_axis_tdata  = 8'h00;  // [7:0] stream_byte
  logic                          s_axis_tlast  = 1'b0;   // final_byte
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  // [31:0] unit_offset, [63:32] unit_size, [69:64] unit_type,
  // [75:70] layer_id, [79:76] temporal_id
  logic [anbs_pkg::OutDataW-1:0] m_axis_tdata;

  annexb_nal_unit_splitter #(
    .POSITION_BITS(PosBits)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // Scanner state of the predictor.
  logic [63:0] pos_q;
  logic [63:0] unit_start_q;
  logic [63:0] last_nz_q;
  logic [1:0]  zero_run_q;
  logic        in_unit_q;
  logic        nz_seen_q;
  logic [7:0]  hdr_first_q;
  logic [7:0]  hdr_second_q;
  int          hdr_cnt_q;

  stim_row_t   stim [$];
  logic [7:0]  buf_q [$];
  nal_info_t   expected_units [$];

  int          acc_n      = 0;
  int          unit_n     = 0;
  int          buf_n      = 0;
  int          err_n      = 0;
  int          in_stall_n = 0;
  int          cycle_n    = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [63:0] next_pos(logic [63:0] p);
    return (p >= PosMax) ? PosMax : p + 64'd1;
  endfunction

  task automatic clear_scan();
    pos_q        = '0;
    unit_start_q = '0;
    last_nz_q    = '0;
    zero_run_q   = '0;
    in_unit_q    = 1'b0;
    nz_seen_q    = 1'b0;
    hdr_first_q  = '0;
    hdr_second_q = '0;
    hdr_cnt_q    = 0;
  endtask

  function automatic bit make_unit(input logic [63:0] len, output nal_info_t u);
    u = '0;
    if (len < 64'd2) return 1'b0;
    u.offset = unit_start_q[31:0];
    u.size   = len[31:0];
    u.ntype  = hdr_first_q[6:1];
    u.layer  = {hdr_first_q[0], hdr_second_q[7:3]};
    u.tid    = {1'b0, hdr_second_q[2:0]} - 4'd1;
    return 1'b1;
  endfunction

  task automatic scan_byte(input logic [7:0] b, input logic fin,
                           output bit got, output nal_info_t u);
    logic [63:0] p;
    bit          sc;
    p   = pos_q;
    got = 1'b0;
    u   = '0;
    sc  = (b == 8'h01) && (zero_run_q == 2'd2);
    if (sc) begin
      if (in_unit_q && nz_seen_q && last_nz_q >= unit_start_q)
        got = make_unit(last_nz_q + 64'd1 - unit_start_q, u);
      in_unit_q    = 1'b1;
      unit_start_q = next_pos(p);
      nz_seen_q    = 1'b0;
      last_nz_q    = '0;
      hdr_cnt_q    = 0;
      zero_run_q   = '0;
    end else begin
      if (in_unit_q) begin
        if (hdr_cnt_q == 0) begin
          hdr_first_q = b;
          hdr_cnt_q   = 1;
        end else if (hdr_cnt_q == 1) begin
          hdr_second_q = b;
          hdr_cnt_q    = 2;
        end
        if (b != 8'h00) begin
          last_nz_q = p;
          nz_seen_q = 1'b1;
        end
      end
      if (b != 8'h00) zero_run_q = 2'd0;
      else if (zero_run_q != 2'd2) zero_run_q = zero_run_q + 2'd1;
    end
    if (fin) begin
      if (!sc && in_unit_q && p >= unit_start_q)
        got = make_unit(p + 64'd1 - unit_start_q, u);
      clear_scan();
    end else begin
      pos_q = next_pos(p);
    end
  endtask

  // Zeros and start-code bytes are favoured so that start codes show up in the content too.
  function automatic logic [7:0] rand_byte();
    unique case ($urandom_range(0, 9))
      0, 1, 2: return 8'h00;
      3:       return 8'h01;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic add_unit();
    int hdr;
    int body;
    int tail;
    buf_q.push_back(8'h00);
    buf_q.push_back(8'h00);
    if ($urandom_range(0, 3) == 0) buf_q.push_back(8'h00);
    buf_q.push_back(8'h01);
    hdr  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1) : 2;
    body = $urandom_range(0, 6);
    tail = $urandom_range(0, 2);
    repeat (hdr) buf_q.push_back(8'($urandom_range(0, 255)));
    repeat (body) buf_q.push_back(rand_byte());
    repeat (tail) buf_q.push_back(8'h00);
  endtask

  task automatic close_buffer();
    stim_row_t r;
    foreach (buf_q[i]) begin
      r     = '0;
      r.b   = buf_q[i];
      r.fin = (i == buf_q.size() - 1);
      stim.push_back(r);
    end
    buf_q.delete();
  endtask

  task automatic add_random_buffer();
    int kind;
    int n;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      n = $urandom_range(1, 20);
      repeat (n) buf_q.push_back(rand_byte());
    end else begin
      n = $urandom_range(0, 3);
      repeat (n) buf_q.push_back(rand_byte());
      n = $urandom_range(1, 5);
      repeat (n) add_unit();
      if (kind == 1) begin
        // cut the buffer short anywhere
        n = $urandom_range(1, buf_q.size());
        while (buf_q.size() > n) void'(buf_q.pop_back());
      end else if ($urandom_range(0, 3) == 0) begin
        buf_q.push_back(8'h00);
        buf_q.push_back(8'h00);
        buf_q.push_back(8'h01);
      end
    end
    close_buffer();
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_n++;
    end
  endtask

  // Predict on every accepted byte word.
  always @(posedge clk_i) begin : scan_inputs
    stim_row_t row;
    nal_info_t u;
    bit        got;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      row = stim[acc_n];
      acc_n++;
      if (s_axis_tlast) buf_n++;
      scan_byte(s_axis_tdata, s_axis_tlast, got, u);
      if (row.typed) expected_units.push_back(row.unit);
      else if (got) expected_units.push_back(u);
    end
    if (rst_ni && s_axis_tvalid && !s_axis_tready) in_stall_n++;
  end

  always @(posedge clk_i) begin : check_units
    nal_info_t got;
    nal_info_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (expected_units.size() == 0) begin
        $error("unit at offset %0d with no unit pending", got.offset);
        err_n++;
      end else begin
        want = expected_units.pop_front();
        check_field("unit_offset", want.offset, got.offset);
        check_field("unit_size", want.size, got.size);
        check_field("unit_type", 32'(want.ntype), 32'(got.ntype));
        check_field("layer_id", 32'(want.layer), 32'(got.layer));
        check_field("temporal_id", 32'(want.tid), 32'(got.tid));
        unit_n++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_n++;
    if (cycle_n > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // Output side: random stalls per word, bursts without stalls, one long hold-off.
  initial begin : drain_units
    int stall;
    int k;
    bit burst;
    k     = 0;
    burst = 1'b0;
    forever begin
      if (k % 32 == 0) burst = ($urandom_range(0, 3) == 0);
      stall = burst ? 0 : $urandom_range(0, 15);
      if (k == PressureAt) stall = PressureCycles;
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      k++;
    end
  end

  initial begin : feed_bytes
    int        gap;
    bit        burst;
    stim_row_t r;
    burst = 1'b0;
    clear_scan();
    for (int i = 0; i < DirRows; i++) stim.push_back(DirTable[i]);
    while (stim.size() < DirRows + RandItems) add_random_buffer();

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < stim.size(); i++) begin
      if (i % 64 == 0) burst = ($urandom_range(0, 3) == 0);
      gap = burst ? 0 : $urandom_range(0, 15);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      r = stim[i];
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= r.b;
      s_axis_tlast  <= r.fin;
      do @(posedge clk_i); while (!s_axis_tready);
    end
    s_axis_tvalid <= 1'b0;

    while (acc_n < stim.size() || expected_units.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);

    $display("Scanned %0d bytes in %0d buffers under random gaps and bursts.",
             acc_n, buf_n);
    $display("Checked %0d units; input held off for %0d cycles.", unit_n, in_stall_n);
    if (err_n == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+design
design/anbs_pkg.sv
design/anbs_front.sv
design/anbs_queue.sv
design/anbs_back.sv
design/annexb_nal_unit_splitter.sv
tb/tb_top.sv
